// ----- rtl/core/snf_pkg.sv -----
// Shared constants for the 2D simplex fBm block: formats, skew factors and codes.
// No dependencies; imported by snf_div and the top level of the block.
package snf_pkg;

    // Fixed-point layout of coordinates and corner terms
    localparam int FRAC       = 16;
    localparam int TABLE_SIZE = 256;
    localparam int TABLE_AW   = 8;
    localparam int MAX_OCTAVES_DEF = 8;

    // Skew / unskew factors in Q0.32
    localparam logic signed [31:0] SKEW_Q32   = 32'sd1572067134;
    localparam logic signed [31:0] UNSKEW_Q32 = 32'sd907633384;
    localparam int ONE  = 1 << FRAC;
    localparam int HALF = 1 << (FRAC - 1);
    localparam int G2   = 907633384 >> (32 - FRAC);

    // Per-octave weighting
    localparam int FALLOFF_SCALE = 70;
    localparam logic [16:0] AMP_ONE = 17'h10000;
    localparam logic [15:0] PERSIST_RST = 16'h8000;
    localparam logic [3:0]  OCTAVES_RST = 4'd4;

    // Quotient bits kept by the normalizing divider
    localparam int QW = 20;

    // Request operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // Configuration register indexes
    localparam logic CFG_OCTAVES = 1'b0;
    localparam logic CFG_PERSIST = 1'b1;

endpackage

// ----- rtl/core/snf_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module snf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/snf_div.sv -----
// Restoring divider that normalizes the weighted octave sum, one quotient bit per cycle.
// Depends on snf_pkg (quotient width).
module snf_div #(
    parameter int TOTAL_W = 48,
    parameter int ASUM_W  = 21
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [TOTAL_W-1:0] i_total,
    input  logic [ASUM_W-1:0]         i_amp_sum,
    output logic                      o_done,
    output logic signed [15:0]        o_result
);
    import snf_pkg::*;

    localparam int DW = ASUM_W + 2;
    localparam int RW = DW + QW;
    localparam int CW = $clog2(QW + 1);

    logic [RW-1:0]      r_rem;
    logic [RW-1:0]      r_dsh;
    logic [QW-1:0]      r_q;
    logic [CW-1:0]      r_cnt;
    logic               r_busy;
    logic               r_done;
    logic               r_neg;
    logic [TOTAL_W-1:0] w_mag;

    // Magnitude of the dividend; divisor is four times the amplitude sum
    assign w_mag = i_total[TOTAL_W-1] ? TOTAL_W'(-i_total) : TOTAL_W'(i_total);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= RW'(w_mag);
                r_dsh  <= RW'({i_amp_sum, 2'b00}) << (QW - 1);
                r_q    <= '0;
                r_neg  <= i_total[TOTAL_W-1];
                r_cnt  <= CW'(QW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // one trial subtraction per cycle
                if (r_rem >= r_dsh) begin
                    r_rem <= r_rem - r_dsh;
                    r_q   <= {r_q[QW-2:0], 1'b1};
                end else begin
                    r_q   <= {r_q[QW-2:0], 1'b0};
                end
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Sign and saturate to Q2.14
    always_comb begin
        if (!r_neg) begin
            o_result = (r_q > QW'(32767)) ? 16'sh7FFF : $signed(r_q[15:0]);
        end else begin
            o_result = (r_q > QW'(32768)) ? 16'sh8000 : $signed(16'(-r_q));
        end
    end

    assign o_done = r_done;

`ifndef NO_ASSERTIONS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy)) else $error("divider done without work");
`endif
endmodule

// ----- rtl/core/simplex_noise_2d_fbm.sv -----
// Top level of the 2D simplex fBm block: request sequencer, octave datapath,
// permutation table RAM. Depends on snf_pkg, snf_ram, snf_div.
//
// Usage:
//  - Request channel (i_valid/o_ready): i_operation selects a table load
//    (writes i_table_value at i_table_index, no result) or an evaluation
//    of the point i_x_coord/i_y_coord in signed Q16.16.
//  - Result channel (o_valid/i_ready): one o_noise_value (Q2.14) per
//    evaluation, in request order.
//  - Config channel (i_cfg_valid/o_cfg_ready): index 0 octave count,
//    index 1 persistence; always ready, write only while idle.
//  - A load leaves o_ready high for the next request. An evaluation
//    raises o_valid when its result enters the output register, and
//    o_ready returns together with it. Each octave makes six reads of the
//    permutation RAM, the last three indexed by the first three, and runs
//    its three corners through one shared multiplier path; the normalizing
//    divider produces one quotient bit per cycle.
//  - One request is worked on at a time. A finished result waits in the
//    output register; the next request is accepted meanwhile, and a new
//    result waits only if the previous one has not been taken.
//  - Reset sets octave count 4, persistence 0.5; the table content is
//    undefined until all 256 entries are loaded.
module simplex_noise_2d_fbm #(
    parameter int MAX_OCTAVES = snf_pkg::MAX_OCTAVES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_operation,
    input  logic [7:0]         i_table_index,
    input  logic [7:0]         i_table_value,
    input  logic signed [31:0] i_x_coord,
    input  logic signed [31:0] i_y_coord,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_noise_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import snf_pkg::*;

    localparam int OW      = $clog2(MAX_OCTAVES + 1);
    localparam int ASUM_W  = 17 + OW;
    localparam int TOTAL_W = 24 + 17 + OW;

    typedef enum logic [3:0] {
        S_IDLE, S_SCALE, S_SKEW, S_CELL, S_UNSK, S_OFFS, S_CORN, S_HASH,
        S_CSQ, S_CT, S_CT2, S_CT4, S_CDOT, S_N1, S_N2, S_DIV
    } t_state;

    t_state r_state;
    logic   r_out_pend;

    // configuration
    logic [3:0]  r_octaves;
    logic [15:0] r_persist;

    // point and octave control
    logic signed [31:0] r_x, r_y, r_xs, r_ys;
    logic [OW-1:0]      r_k, r_lim, w_lim;
    logic signed [33:0] r_s;
    logic signed [19:0] r_i, r_j;
    logic signed [35:0] r_t;
    logic signed [23:0] r_cx [3];
    logic signed [23:0] r_cy [3];
    logic               r_i1;
    logic [2:0]         r_hs;
    logic [7:0]         r_pv [6];
    logic [1:0]         r_cn;

    // corner path
    logic signed [31:0] r_xx, r_yy;
    logic signed [24:0] r_dot;
    logic [16:0]        r_tv;
    logic               r_tneg;
    logic signed [19:0] r_acc;
    logic signed [23:0] r_n;

    // octave accumulation
    logic signed [TOTAL_W-1:0] r_total;
    logic [ASUM_W-1:0]         r_asum;
    logic [16:0]               r_amp;

    logic               r_out_valid;
    logic signed [15:0] r_out_data;
    logic               r_div_start;

    // combinational terms
    logic signed [32:0] w_sum;
    logic signed [63:0] w_sprod;
    logic signed [34:0] w_xsum, w_ysum;
    logic signed [20:0] w_ij;
    logic signed [55:0] w_uprod;
    logic signed [39:0] w_x0, w_y0;
    logic signed [23:0] w_cx, w_cy;
    logic [7:0]         w_h;
    logic signed [47:0] w_xx, w_yy;
    logic signed [32:0] w_t;
    logic [33:0]        w_tt;
    logic signed [43:0] w_cd;
    logic signed [TOTAL_W-1:0] w_wt;
    logic [32:0]        w_na;
    logic [7:0]         w_raddr, w_rdata, w_ii, w_jj;
    logic               w_accept, w_we, w_div_done, w_out_load;
    logic signed [15:0] w_div_res;

    assign w_accept = i_valid && o_ready;
    assign w_we     = w_accept && (i_operation == OP_LOAD);
    assign o_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid  = r_out_valid;
    assign o_noise_value = r_out_data;

    // Finished result moves into the output register once it is empty or being taken
    assign w_out_load = (r_state == S_DIV) && r_out_pend && (!r_out_valid || i_ready);

    // Effective octave count: zero means one, clipped at the maximum
    always_comb begin
        if (r_octaves == 4'd0) begin
            w_lim = OW'(1);
        end else if (int'(r_octaves) > MAX_OCTAVES) begin
            w_lim = OW'(MAX_OCTAVES);
        end else begin
            w_lim = OW'(r_octaves);
        end
    end

    // Skew, cell and unskew arithmetic
    assign w_sum   = 33'(r_xs) + 33'(r_ys);
    assign w_sprod = w_sum * SKEW_Q32;
    assign w_xsum  = 35'(r_xs) + 35'(r_s);
    assign w_ysum  = 35'(r_ys) + 35'(r_s);
    assign w_ij    = 21'(r_i) + 21'(r_j);
    assign w_uprod = w_ij * UNSKEW_Q32;
    assign w_x0    = 40'(r_xs) - (40'(r_i) <<< FRAC) + 40'(r_t);
    assign w_y0    = 40'(r_ys) - (40'(r_j) <<< FRAC) + 40'(r_t);

    // Current corner and its hash
    assign w_cx = r_cx[r_cn];
    assign w_cy = r_cy[r_cn];
    always_comb begin
        case (r_cn)
            2'd0:    w_h = r_pv[3];
            2'd1:    w_h = r_pv[4];
            default: w_h = r_pv[5];
        endcase
    end

    assign w_xx = 48'(w_cx) * 48'(w_cx);
    assign w_yy = 48'(w_cy) * 48'(w_cy);
    assign w_t  = 33'(HALF) - 33'(r_xx) - 33'(r_yy);
    assign w_tt = 34'(r_tv) * 34'(r_tv);
    assign w_cd = 44'($signed({1'b0, r_tv})) * 44'(r_dot);
    assign w_wt = TOTAL_W'(r_n) * TOTAL_W'($signed({1'b0, r_amp}));
    assign w_na = 33'(r_amp) * 33'(r_persist);

    // Permutation RAM read address for each hash step
    assign w_ii = r_i[7:0];
    assign w_jj = r_j[7:0];
    always_comb begin
        case (r_hs)
            3'd0:    w_raddr = w_jj;
            3'd1:    w_raddr = w_jj + {7'd0, ~r_i1};
            3'd2:    w_raddr = w_jj + 8'd1;
            3'd3:    w_raddr = w_ii + r_pv[0];
            3'd4:    w_raddr = w_ii + {7'd0, r_i1} + r_pv[1];
            3'd5:    w_raddr = w_ii + 8'd1 + r_pv[2];
            default: w_raddr = 8'd0;
        endcase
    end

    snf_ram #(
        .WIDTH (8),
        .DEPTH (TABLE_SIZE)
    ) u_perm (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_table_index),
        .i_wdata (i_table_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    snf_div #(
        .TOTAL_W (TOTAL_W),
        .ASUM_W  (ASUM_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_div_start),
        .i_total   (r_total),
        .i_amp_sum (r_asum),
        .o_done    (w_div_done),
        .o_result  (w_div_res)
    );

    // Sequencer, datapath registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_out_pend  <= 1'b0;
            r_div_start <= 1'b0;
            r_octaves   <= OCTAVES_RST;
            r_persist   <= PERSIST_RST;
            r_hs        <= '0;
            r_cn        <= '0;
            r_k         <= '0;
        end else begin
            r_div_start <= 1'b0;
            // output register: a new result replaces one that is being taken
            if (w_out_load) begin
                r_out_valid <= 1'b1;
                r_out_data  <= w_div_res;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_OCTAVES: r_octaves <= i_cfg_data[3:0];
                    CFG_PERSIST: r_persist <= i_cfg_data;
                    default:     r_persist <= r_persist;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_operation == OP_EVAL)) begin
                        r_x     <= i_x_coord;
                        r_y     <= i_y_coord;
                        r_k     <= '0;
                        r_lim   <= w_lim;
                        r_total <= '0;
                        r_asum  <= '0;
                        r_amp   <= AMP_ONE;
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_xs    <= r_x <<< r_k;
                    r_ys    <= r_y <<< r_k;
                    r_state <= S_SKEW;
                end
                S_SKEW: begin
                    r_s     <= 34'(w_sprod >>> 32);
                    r_state <= S_CELL;
                end
                S_CELL: begin
                    r_i     <= 20'(w_xsum >>> FRAC);
                    r_j     <= 20'(w_ysum >>> FRAC);
                    r_state <= S_UNSK;
                end
                S_UNSK: begin
                    r_t     <= 36'(w_uprod >>> (32 - FRAC));
                    r_state <= S_OFFS;
                end
                S_OFFS: begin
                    r_cx[0] <= 24'(w_x0);
                    r_cy[0] <= 24'(w_y0);
                    r_state <= S_CORN;
                end
                S_CORN: begin
                    // middle corner steps along x when x0 > y0, else along y
                    r_i1    <= (r_cx[0] > r_cy[0]);
                    r_cx[1] <= r_cx[0] - ((r_cx[0] > r_cy[0]) ? 24'(ONE) : 24'sd0)
                               + 24'(G2);
                    r_cy[1] <= r_cy[0] - ((r_cx[0] > r_cy[0]) ? 24'sd0 : 24'(ONE))
                               + 24'(G2);
                    r_cx[2] <= r_cx[0] - 24'(ONE) + 24'(2 * G2);
                    r_cy[2] <= r_cy[0] - 24'(ONE) + 24'(2 * G2);
                    r_hs    <= '0;
                    r_state <= S_HASH;
                end
                S_HASH: begin
                    // read data lags the address by one step
                    case (r_hs)
                        3'd1:    r_pv[0] <= w_rdata;
                        3'd2:    r_pv[1] <= w_rdata;
                        3'd3:    r_pv[2] <= w_rdata;
                        3'd4:    r_pv[3] <= w_rdata;
                        3'd5:    r_pv[4] <= w_rdata;
                        3'd6:    r_pv[5] <= w_rdata;
                        default: r_pv[0] <= r_pv[0];
                    endcase
                    if (r_hs == 3'd6) begin
                        r_cn    <= '0;
                        r_acc   <= '0;
                        r_state <= S_CSQ;
                    end else begin
                        r_hs <= r_hs + 3'd1;
                    end
                end
                S_CSQ: begin
                    r_xx <= 32'(w_xx >>> FRAC);
                    r_yy <= 32'(w_yy >>> FRAC);
                    case (w_h[1:0])
                        2'd0:    r_dot <= 25'(w_cx) + 25'(w_cy);
                        2'd1:    r_dot <= 25'(w_cy) - 25'(w_cx);
                        2'd2:    r_dot <= -25'(w_cx) - 25'(w_cy);
                        default: r_dot <= 25'(w_cx) - 25'(w_cy);
                    endcase
                    r_state <= S_CT;
                end
                S_CT: begin
                    r_tneg  <= w_t[32];
                    r_tv    <= 17'(w_t);
                    r_state <= S_CT2;
                end
                S_CT2: begin
                    r_tv    <= 17'(w_tt >> FRAC);
                    r_state <= S_CT4;
                end
                S_CT4: begin
                    r_tv    <= 17'(w_tt >> FRAC);
                    r_state <= S_CDOT;
                end
                S_CDOT: begin
                    // a corner outside its radius adds nothing
                    if (!r_tneg) begin
                        r_acc <= r_acc + 20'(w_cd >>> FRAC);
                    end
                    if (r_cn == 2'd2) begin
                        r_state <= S_N1;
                    end else begin
                        r_cn    <= r_cn + 2'd1;
                        r_state <= S_CSQ;
                    end
                end
                S_N1: begin
                    r_n     <= 24'(r_acc) * 24'(FALLOFF_SCALE);
                    r_state <= S_N2;
                end
                S_N2: begin
                    r_total <= r_total + w_wt;
                    r_asum  <= r_asum + ASUM_W'(r_amp);
                    r_amp   <= 17'(w_na >> 16);
                    if ((r_k + 1'b1) == r_lim) begin
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_SCALE;
                    end
                end
                S_DIV: begin
                    // divider holds its result until the next start
                    if (w_div_done) begin
                        r_out_pend <= 1'b1;
                    end
                    if (w_out_load) begin
                        r_out_pend <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_IDLE)) else $error("table write while busy");
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV)) else $error("divider result unexpected");
    a_octave_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCALE) |-> (r_k < r_lim)) else $error("octave index overrun");
    a_hash_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HASH) |-> (r_hs <= 3'd6)) else $error("hash step overrun");
`endif
endmodule
